### rtl/edge_period_high_time_capture_core_defines.svh
// ----------------------------------------------------------------------------
// edge period / high time capture: assertion macros
// clocked assertion helpers shared by the checker files
// ----------------------------------------------------------------------------
`ifndef EDGE_PERIOD_HIGH_TIME_CAPTURE_CORE_DEFINES_SVH
`define EDGE_PERIOD_HIGH_TIME_CAPTURE_CORE_DEFINES_SVH

// property checked while out of reset
`define EPHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define EPHT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/epht_pkg.sv
// ----------------------------------------------------------------------------
// epht_pkg
// shared types and constants of the edge period / high time capture core
// ----------------------------------------------------------------------------
`default_nettype none

package epht_pkg;

  localparam int unsigned TickW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SubShift = 4;

  localparam logic [TickW-1:0] TICK_TOP_RESET = 16'd15999;
  localparam logic [TimeW-1:0] US_PER_MS      = 32'd1000;

  typedef struct packed {
    logic clear_ready;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic             high_update;
    logic             period_update;
    logic             ready_res;
    logic [TimeW-1:0] high_us;
    logic [TimeW-1:0] period_us;
    logic [TimeW-1:0] time_us;
  } res_t;

endpackage

`default_nettype wire

### rtl/epht_timebase.sv
// ----------------------------------------------------------------------------
// epht_timebase
// sub-millisecond tick counter and running microsecond base of whole ms
// ----------------------------------------------------------------------------
`default_nettype none

module epht_timebase (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [epht_pkg::TickW-1:0]  tick_top,
  output logic      [epht_pkg::TimeW-1:0]  now_us
);

  logic [epht_pkg::TickW-1:0] sub_r;
  logic [epht_pkg::TickW-1:0] sub_nxt;
  logic [epht_pkg::TimeW-1:0] base_r;
  logic [epht_pkg::TimeW-1:0] base_nxt;
  logic                       wrap;

  assign wrap   = (sub_r >= tick_top);
  assign now_us = base_r + epht_pkg::TimeW'(sub_r >> epht_pkg::SubShift);

  always_comb begin
    if (wrap) begin
      sub_nxt  = '0;
      base_nxt = base_r + epht_pkg::US_PER_MS;
    end else begin
      sub_nxt  = sub_r + epht_pkg::TickW'(1);
      base_nxt = base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= '0;
      base_r <= '0;
    end else if (step) begin
      sub_r  <= sub_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/epht_capture.sv
// ----------------------------------------------------------------------------
// epht_capture
// edge detection, period and high time measurement, sticky ready flag
// ----------------------------------------------------------------------------
`default_nettype none

module epht_capture (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire epht_pkg::in_item_t          item,
  input  wire logic [epht_pkg::TimeW-1:0]  now_us,
  output epht_pkg::res_t                   res
);

  logic [epht_pkg::TimeW-1:0] last_rise_r, last_rise_nxt;
  logic [epht_pkg::TimeW-1:0] period_r, period_nxt;
  logic [epht_pkg::TimeW-1:0] high_r, high_nxt;
  logic                       seen_rise_r, seen_rise_nxt;
  logic                       await_fall_r, await_fall_nxt;
  logic                       prev_level_r;
  logic                       ready_r, ready_nxt;
  logic                       p_upd, h_upd;
  logic [epht_pkg::TimeW-1:0] since_rise;

  assign since_rise = now_us - last_rise_r;

  always_comb begin
    last_rise_nxt  = last_rise_r;
    period_nxt     = period_r;
    high_nxt       = high_r;
    seen_rise_nxt  = seen_rise_r;
    await_fall_nxt = await_fall_r;
    ready_nxt      = ready_r & ~item.clear_ready;
    p_upd          = 1'b0;
    h_upd          = 1'b0;
    if (!await_fall_r) begin
      if (!prev_level_r && item.pin_level) begin
        if (seen_rise_r) begin
          period_nxt = since_rise;
          ready_nxt  = 1'b1;
          p_upd      = 1'b1;
        end
        last_rise_nxt  = now_us;
        seen_rise_nxt  = 1'b1;
        await_fall_nxt = 1'b1;
      end
    end else if (prev_level_r && !item.pin_level) begin
      high_nxt       = since_rise;
      h_upd          = 1'b1;
      await_fall_nxt = 1'b0;
    end
  end

  always_comb begin
    res.time_us       = now_us;
    res.period_us     = period_nxt;
    res.high_us       = high_nxt;
    res.ready_res     = ready_nxt;
    res.period_update = p_upd;
    res.high_update   = h_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rise_r  <= '0;
      period_r     <= '0;
      high_r       <= '0;
      seen_rise_r  <= 1'b0;
      await_fall_r <= 1'b0;
      prev_level_r <= 1'b1;
      ready_r      <= 1'b0;
    end else if (step) begin
      last_rise_r  <= last_rise_nxt;
      period_r     <= period_nxt;
      high_r       <= high_nxt;
      seen_rise_r  <= seen_rise_nxt;
      await_fall_r <= await_fall_nxt;
      prev_level_r <= item.pin_level;
      ready_r      <= ready_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/edge_period_high_time_capture_core.sv
// result path: item held in the input register, its result registered in the result register on each step
// throughput: one item per cycle while out_tready does not stall, set by input and result registers
// each item advances the tick counter and ms base by one timebase tick
// reset (rst_n low, synchronous): counters, edge state and ready flag cleared, previous
// pin level set high, tick_top back to 15999, pipeline emptied
// ----------------------------------------------------------------------------
// edge_period_high_time_capture_core
// input capture of rising-to-rising period and high time on a microsecond base
// ----------------------------------------------------------------------------
`default_nettype none

module edge_period_high_time_capture_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config write
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data,   // tick_top
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // pin_level, clear_ready, unused bits
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [103:0] out_tdata   // time_us, period_us, high_us, ready_res,
                                        // period_update, high_update, zero pad
);

  logic [epht_pkg::TickW-1:0] tick_top_r;
  logic                       in_valid_r;
  epht_pkg::in_item_t         in_item_r;
  logic                       out_valid_r;
  epht_pkg::res_t             out_res_r;
  epht_pkg::res_t             res;
  logic [epht_pkg::TimeW-1:0] now_us;
  logic                       advance;
  logic                       step;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_top_r <= epht_pkg::TICK_TOP_RESET;
    end else if (cfg_valid) begin
      tick_top_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.pin_level   <= in_tdata[0];
      in_item_r.clear_ready <= in_tdata[1];
    end
  end

  epht_timebase u_timebase (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .tick_top (tick_top_r),
    .now_us   (now_us)
  );

  epht_capture u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .now_us (now_us),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r};

endmodule

`default_nettype wire

### rtl/epht_checker.sv
// ----------------------------------------------------------------------------
// epht_checker
// port-level checks of the capture core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "edge_period_high_time_capture_core_defines.svh"

module epht_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);

  `EPHT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `EPHT_ASSERT(a_period_sets_ready, clk, rst_n, out_tvalid && out_tdata[97] |-> out_tdata[96], "period update without ready flag")
  `EPHT_ASSERT(a_updates_exclusive, clk, rst_n, out_tvalid |-> !(out_tdata[97] && out_tdata[98]), "period and high update on one tick")
  `EPHT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind edge_period_high_time_capture_core epht_checker u_epht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
